@@ rtl/core/bzp_pkg.sv @@
// Shared types and constants for the de Casteljau Bezier point evaluator.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
`default_nettype none

package bzp_pkg;

    localparam int MAX_POINTS = 128;
    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 16;
    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int WORK_BITS  = COORD_BITS + FRAC_BITS;

    // curve parameter is unsigned Q1.16 on a 17-bit port
    localparam int T_BITS = 16;
    localparam logic [T_BITS:0] T_ONE = (T_BITS + 1)'(1) << T_BITS;

    localparam int PCOUNT_BITS = 8;
    localparam logic [PCOUNT_BITS-1:0] PCOUNT_RESET = PCOUNT_BITS'(2);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_coord_pt;

    typedef struct packed {
        logic [WORK_BITS-1:0] x;
        logic [WORK_BITS-1:0] y;
    } t_work_pt;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic            shift;  // take the left neighbor's point
        logic            step;   // interpolate with the right neighbor's point
        logic [T_BITS:0] t;
    } t_cell_ctrl;

endpackage

`default_nettype wire

@@ rtl/core/bzp_point_store.sv @@
// Control point store: one write port, one registered read port.
// Depends on bzp_pkg for sizes and the coordinate pair type.
`default_nettype none

module bzp_point_store (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [bzp_pkg::IDX_BITS-1:0] i_waddr,
    input  wire bzp_pkg::t_coord_pt           i_wdata,
    input  wire logic                         i_re,
    input  wire logic [bzp_pkg::IDX_BITS-1:0] i_raddr,
    output bzp_pkg::t_coord_pt                o_rdata
);

    bzp_pkg::t_coord_pt mem [bzp_pkg::MAX_POINTS];
    bzp_pkg::t_coord_pt r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/bzp_cell.sv @@
// One interpolation cell: holds a working point, shifts it right during fill
// or blends it with its right neighbor during a pass. Depends on bzp_pkg.
`default_nettype none

module bzp_cell (
    input  wire logic                i_clk,
    input  wire bzp_pkg::t_cell_ctrl i_ctrl,
    input  wire bzp_pkg::t_work_pt   i_left,
    input  wire bzp_pkg::t_work_pt   i_right,
    output bzp_pkg::t_work_pt        o_pt
);

    localparam int W         = bzp_pkg::WORK_BITS;
    localparam int PROD_BITS = W + bzp_pkg::T_BITS + 3;

    bzp_pkg::t_work_pt r_pt;
    bzp_pkg::t_work_pt n_pt;

    // b + ((t * (a - b)) >>> T_BITS), equal to (t*a + (1-t)*b) >> T_BITS
    function automatic logic [W-1:0] lerp(
        input logic [bzp_pkg::T_BITS:0] t,
        input logic [W-1:0]             a,
        input logic [W-1:0]             b
    );
        logic signed [W:0]           diff;
        logic signed [PROD_BITS-1:0] t_ext;
        logic signed [PROD_BITS-1:0] d_ext;
        logic signed [PROD_BITS-1:0] prod;
        logic signed [PROD_BITS-1:0] sum;
        diff  = $signed({1'b0, a}) - $signed({1'b0, b});
        t_ext = $signed({{(PROD_BITS - bzp_pkg::T_BITS - 1){1'b0}}, t});
        d_ext = {{(PROD_BITS - W - 1){diff[W]}}, diff};
        prod  = t_ext * d_ext;
        sum   = (prod >>> bzp_pkg::T_BITS)
              + $signed({{(PROD_BITS - W){1'b0}}, b});
        return sum[W-1:0];
    endfunction

    always_comb begin
        n_pt = r_pt;
        priority if (i_ctrl.shift) begin
            n_pt = i_left;
        end else if (i_ctrl.step) begin
            n_pt.x = lerp(i_ctrl.t, r_pt.x, i_right.x);
            n_pt.y = lerp(i_ctrl.t, r_pt.y, i_right.y);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pt <= n_pt;
    end

    assign o_pt = r_pt;

endmodule

`default_nettype wire

@@ rtl/core/bezier_point_evaluator_top.sv @@
// Top level of the Bezier point evaluator: sequencer, control point store,
// row of interpolation cells and output register. Depends on bzp_pkg,
// bzp_point_store and bzp_cell.
`default_nettype none

// Load beats (kind = 0) write one control point into the store and finish in
// the cycle they are accepted. Evaluate beats (kind = 1) return one curve
// point by de Casteljau interpolation over control points 0 .. point_count-1;
// t = 0 gives the last point, t = 1.0 (65536) the first, and t above 1.0
// counts as 1.0. A point_count of 0 acts as 1, above 128 as 128. An evaluate
// runs in order, with k the clamped point count: the fill streams the k points
// out of the store's single read port into the cell row, a flush state covers
// the read latency, k-1 interpolation passes follow, in which every cell
// blends with its right neighbor at once, and the done state hands the result
// to the output register as soon as that register is free. The block
// takes one beat at a time, but a finished result can wait in the output
// register while the next beats are accepted. Write point_count only while
// no evaluate is in flight. Reading a control point never loaded since reset
// gives an undefined result.
module bezier_point_evaluator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: point_count
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_data,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_kind,
    input  wire logic [6:0]  i_point_index,
    input  wire logic [9:0]  i_x_in,
    input  wire logic [9:0]  i_y_in,
    input  wire logic [16:0] i_t_value,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [9:0]       o_x_out,
    output logic [9:0]       o_y_out
);

    localparam int MAXP = bzp_pkg::MAX_POINTS;
    localparam int IB   = bzp_pkg::IDX_BITS;
    localparam int CB   = bzp_pkg::COORD_BITS;
    localparam int FB   = bzp_pkg::FRAC_BITS;
    localparam int WB   = bzp_pkg::WORK_BITS;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FILL  = 5'b00010,
        S_FLUSH = 5'b00100,
        S_STEP  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                            r_state, n_state;
    logic [bzp_pkg::PCOUNT_BITS-1:0]   r_point_count;
    logic [bzp_pkg::T_BITS:0]          r_t, n_t;
    logic [IB-1:0]                     r_addr, n_addr;
    logic [IB-1:0]                     r_passes, n_passes;
    logic                              r_rd_valid, n_rd_valid;
    logic                              r_out_valid, n_out_valid;
    logic [CB-1:0]                     r_x_out, n_x_out;
    logic [CB-1:0]                     r_y_out, n_y_out;

    logic                              in_fire;
    logic                              rd_en;
    logic                              st_we;
    logic [IB-1:0]                     last_idx;
    bzp_pkg::t_coord_pt                st_wdata;
    bzp_pkg::t_coord_pt                st_rdata;
    bzp_pkg::t_work_pt                 load_pt;
    bzp_pkg::t_cell_ctrl               cell_ctrl;
    bzp_pkg::t_work_pt                 cell_pt [MAXP];

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    // index of the last control point in use, after clamping the count
    always_comb begin
        priority if (r_point_count == '0) begin
            last_idx = '0;
        end else if (32'(r_point_count) > MAXP) begin
            last_idx = IB'(MAXP - 1);
        end else begin
            last_idx = IB'(r_point_count - 1'b1);
        end
    end

    // ---------------------------------------------------------------
    // Control point store
    // ---------------------------------------------------------------
    assign st_we      = in_fire && (i_kind == bzp_pkg::KIND_LOAD)
                        && (32'(i_point_index) < MAXP);
    assign st_wdata.x = CB'(i_x_in);
    assign st_wdata.y = CB'(i_y_in);

    bzp_point_store u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (IB'(i_point_index)),
        .i_wdata (st_wdata),
        .i_re    (rd_en),
        .i_raddr (r_addr),
        .o_rdata (st_rdata)
    );

    // ---------------------------------------------------------------
    // Cell row: fill shifts points in at cell 0 (last point first),
    // each pass blends every cell with its right neighbor
    // ---------------------------------------------------------------
    assign load_pt.x = {st_rdata.x, {FB{1'b0}}};
    assign load_pt.y = {st_rdata.y, {FB{1'b0}}};

    assign cell_ctrl.shift = r_rd_valid;
    assign cell_ctrl.step  = (r_state == S_STEP);
    assign cell_ctrl.t     = r_t;

    for (genvar g = 0; g < MAXP; g++) begin : g_cell
        bzp_pkg::t_work_pt left_pt;
        bzp_pkg::t_work_pt right_pt;

        if (g == 0) begin : g_head
            assign left_pt = load_pt;
        end else begin : g_body
            assign left_pt = cell_pt[g-1];
        end

        // the last cell's right input only feeds values past the active span
        if (g == MAXP - 1) begin : g_tail
            assign right_pt = cell_pt[g];
        end else begin : g_mid
            assign right_pt = cell_pt[g+1];
        end

        bzp_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (cell_ctrl),
            .i_left  (left_pt),
            .i_right (right_pt),
            .o_pt    (cell_pt[g])
        );
    end

    // ---------------------------------------------------------------
    // Sequencer and output register
    // ---------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_t         = r_t;
        n_addr      = r_addr;
        n_passes    = r_passes;
        n_rd_valid  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_x_out     = r_x_out;
        n_y_out     = r_y_out;
        rd_en       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire && (i_kind == bzp_pkg::KIND_EVAL)) begin
                    n_t      = (i_t_value > bzp_pkg::T_ONE) ? bzp_pkg::T_ONE
                                                            : i_t_value;
                    n_addr   = last_idx;
                    n_passes = last_idx;
                    n_state  = S_FILL;
                end
            end
            S_FILL: begin
                // read from the last point down to point 0
                rd_en      = 1'b1;
                n_rd_valid = 1'b1;
                n_addr     = r_addr - 1'b1;
                if (r_addr == '0) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                // point 0 shifts into cell 0 this cycle
                n_state = (r_passes == '0) ? S_DONE : S_STEP;
            end
            S_STEP: begin
                n_passes = r_passes - 1'b1;
                if (r_passes == IB'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_x_out     = cell_pt[0].x[WB-1:FB];
                    n_y_out     = cell_pt[0].y[WB-1:FB];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_rd_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_point_count <= bzp_pkg::PCOUNT_RESET;
        end else begin
            r_state     <= n_state;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_point_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t      <= n_t;
        r_addr   <= n_addr;
        r_passes <= n_passes;
        r_x_out  <= n_x_out;
        r_y_out  <= n_y_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_x_out     = r_x_out;
    assign o_y_out     = r_y_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_shift_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> ($past(r_state) == S_FILL))
        else $error("cell row shifted without a store read in the prior cycle");

    a_step_has_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (r_passes != '0))
        else $error("interpolation pass with no passes left");

    a_fill_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FILL) && (r_addr != '0)) |=> (r_state == S_FILL))
        else $error("fill ended before point 0 was read");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result appeared without a finished evaluation");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Testbench for bezier_point_evaluator_top: loads control points, evaluates curve points
// and checks every result against an in-bench de Casteljau predictor.
// Depends on bzp_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 11;
    localparam int EVAL_DRAIN      = 2 * bzp_pkg::MAX_POINTS + 8;  // longest evaluate plus margin
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLDOFF_CYCLES  = 400;
    localparam int BEATS_PER_PHASE = 32;
    localparam int NUM_PHASES      = 12;
    localparam int T_MAX_RAW       = 131071;

    typedef struct {
        logic                           kind;
        logic [bzp_pkg::IDX_BITS-1:0]   point_index;
        logic [bzp_pkg::COORD_BITS-1:0] x;
        logic [bzp_pkg::COORD_BITS-1:0] y;
        logic [bzp_pkg::T_BITS:0]       t;
    } t_curve_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // configuration port
    logic                            cfg_we = 1'b0;
    logic [bzp_pkg::PCOUNT_BITS-1:0] cfg_data = '0;

    // input channel, driven by the beat driver
    logic                           in_valid = 1'b0;
    logic                           o_in_ready;
    logic                           in_kind = bzp_pkg::KIND_LOAD;
    logic [bzp_pkg::IDX_BITS-1:0]   in_point_index = '0;
    logic [bzp_pkg::COORD_BITS-1:0] in_x = '0;
    logic [bzp_pkg::COORD_BITS-1:0] in_y = '0;
    logic [bzp_pkg::T_BITS:0]       in_t = '0;

    // output channel
    logic                           o_out_valid;
    logic                           out_ready = 1'b0;
    logic [bzp_pkg::COORD_BITS-1:0] o_x_out;
    logic [bzp_pkg::COORD_BITS-1:0] o_y_out;

    // predictor state: control point store and point_count as the block holds them
    logic [bzp_pkg::COORD_BITS-1:0]  ctl_x [bzp_pkg::MAX_POINTS];
    logic [bzp_pkg::COORD_BITS-1:0]  ctl_y [bzp_pkg::MAX_POINTS];
    logic [bzp_pkg::PCOUNT_BITS-1:0] pcount_model = bzp_pkg::PCOUNT_RESET;

    // generator side: which slots the queued loads have filled so far
    bit [bzp_pkg::MAX_POINTS-1:0] slot_loaded = '0;

    t_curve_beat        pending_beats [$];
    bzp_pkg::t_coord_pt expected_points [$];

    int fail_count    = 0;
    int results_seen  = 0;
    int stall_cycles  = 0;
    int burst_left    = 1;
    int gap_left      = 0;
    int rx_window     = 0;
    int rx_mode       = 0;
    int holdoff_left  = 0;
    int holdoff_at    = 30;

    bezier_point_evaluator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (in_kind),
        .i_point_index (in_point_index),
        .i_x_in        (in_x),
        .i_y_in        (in_y),
        .i_t_value     (in_t),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_x_out       (o_x_out),
        .o_y_out       (o_y_out)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < bzp_pkg::MAX_POINTS; i++) begin
            ctl_x[i] = '0;
            ctl_y[i] = '0;
        end
    end

    // One interpolation step: t*a + (1-t)*b in Q1.16, truncated.
    function automatic logic [63:0] blend(input logic [63:0] t, input logic [63:0] a,
                                          input logic [63:0] b);
        return (t * a + (64'(bzp_pkg::T_ONE) - t) * b) >> bzp_pkg::T_BITS;
    endfunction

    // Curve point at t over control points 0 .. point_count-1, truncated to pixels.
    function automatic bzp_pkg::t_coord_pt casteljau_point(
        input logic [bzp_pkg::T_BITS:0] t_raw);
        logic [63:0]        t;
        logic [63:0]        wx [bzp_pkg::MAX_POINTS];
        logic [63:0]        wy [bzp_pkg::MAX_POINTS];
        int                 k;
        int                 lvl;
        int                 i;
        bzp_pkg::t_coord_pt pt;
        // saturate t above 1.0, clamp the count into 1 .. MAX_POINTS
        t = (t_raw > bzp_pkg::T_ONE) ? 64'(bzp_pkg::T_ONE) : 64'(t_raw);
        k = int'(pcount_model);
        if (k == 0)
            k = 1;
        if (k > bzp_pkg::MAX_POINTS)
            k = bzp_pkg::MAX_POINTS;
        for (i = 0; i < k; i++) begin
            wx[i] = 64'(ctl_x[i]) << bzp_pkg::FRAC_BITS;
            wy[i] = 64'(ctl_y[i]) << bzp_pkg::FRAC_BITS;
        end
        for (lvl = k - 1; lvl >= 1; lvl--) begin
            for (i = 0; i < lvl; i++) begin
                wx[i] = blend(t, wx[i], wx[i + 1]);
                wy[i] = blend(t, wy[i], wy[i + 1]);
            end
        end
        pt.x = wx[0][bzp_pkg::FRAC_BITS +: bzp_pkg::COORD_BITS];
        pt.y = wy[0][bzp_pkg::FRAC_BITS +: bzp_pkg::COORD_BITS];
        return pt;
    endfunction

    // Beat driver: send queued beats in bursts with gaps; hold valid and payload
    // until the beat is taken. Update the predictor on every accepted beat.
    always @(posedge i_clk) begin : beat_driver
        t_curve_beat nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end else begin
            if (in_valid && o_in_ready) begin
                if (in_kind == bzp_pkg::KIND_LOAD) begin
                    ctl_x[in_point_index] = in_x;
                    ctl_y[in_point_index] = in_y;
                end else begin
                    expected_points.push_back(casteljau_point(in_t));
                end
            end
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    nxt = pending_beats.pop_front();
                    in_valid       <= 1'b1;
                    in_kind        <= nxt.kind;
                    in_point_index <= nxt.point_index;
                    in_x           <= nxt.x;
                    in_y           <= nxt.y;
                    in_t           <= nxt.t;
                    burst_left--;
                    if (burst_left == 0) begin
                        // now and then a long burst with no gap at all
                        if ($urandom_range(0, 3) == 0) begin
                            burst_left = 40;
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 12);
                            gap_left   = $urandom_range(1, 8);
                        end
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: ready follows windows of always-ready, mostly-ready and
    // mostly-stalled; twice it holds off for a long stretch so the output
    // register fills and the block stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            out_ready    <= 1'b0;
        end else if (results_seen >= holdoff_at) begin
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_at   <= (holdoff_at == 30) ? 220 : 32'h7fff_ffff;
            out_ready    <= 1'b0;
        end else begin
            if (rx_window == 0) begin
                rx_window <= $urandom_range(20, 120);
                rx_mode   <= $urandom_range(0, 2);
            end else begin
                rx_window <= rx_window - 1;
            end
            case (rx_mode)
                0: begin
                    out_ready <= 1'b1;
                end
                1: begin
                    out_ready <= ($urandom_range(0, 9) < 7);
                end
                default: begin
                    out_ready <= ($urandom_range(0, 9) < 3);
                end
            endcase
        end
    end

    // Result checker: compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin : result_checker
        bzp_pkg::t_coord_pt want;
        if (i_rst_n && o_out_valid && out_ready) begin
            results_seen <= results_seen + 1;
            if (expected_points.size() == 0) begin
                $error("unexpected result beat: x_out=%0d y_out=%0d", o_x_out, o_y_out);
                fail_count++;
            end else begin
                want = expected_points.pop_front();
                if (o_x_out !== want.x) begin
                    $error("x_out mismatch: expected %0d, got %0d", want.x, o_x_out);
                    fail_count++;
                end
                if (o_y_out !== want.y) begin
                    $error("y_out mismatch: expected %0d, got %0d", want.y, o_y_out);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_beat(input logic kind, input int idx, input int x, input int y,
                             input int t);
        t_curve_beat b;
        b.kind        = kind;
        b.point_index = bzp_pkg::IDX_BITS'(idx);
        b.x           = bzp_pkg::COORD_BITS'(x);
        b.y           = bzp_pkg::COORD_BITS'(y);
        b.t           = (bzp_pkg::T_BITS + 1)'(t);
        if (kind == bzp_pkg::KIND_LOAD)
            slot_loaded[b.point_index] = 1'b1;
        pending_beats.push_back(b);
    endtask

    function automatic int pick_coord();
        case ($urandom_range(0, 6))
            0:       return 0;
            1:       return (1 << bzp_pkg::COORD_BITS) - 1;
            default: return $urandom_range(0, (1 << bzp_pkg::COORD_BITS) - 1);
        endcase
    endfunction

    function automatic int pick_t();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return int'(bzp_pkg::T_ONE);
            2:       return $urandom_range(int'(bzp_pkg::T_ONE) + 1, T_MAX_RAW);
            default: return $urandom_range(0, int'(bzp_pkg::T_ONE));
        endcase
    endfunction

    // Wait until every queued beat is taken and every prediction has come back.
    task automatic wait_drained();
        while (pending_beats.size() != 0 || in_valid || expected_points.size() != 0)
            @(posedge i_clk);
    endtask

    // Write point_count with the block idle; let a trailing evaluate finish first.
    task automatic set_point_count(input int value);
        wait_drained();
        repeat (EVAL_DRAIN) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= bzp_pkg::PCOUNT_BITS'(value);
        @(posedge i_clk);
        cfg_we       <= 1'b0;
        pcount_model = bzp_pkg::PCOUNT_BITS'(value);
    endtask

    // Stimulus: directed beats at the reset count, then random phases over a
    // plan of point counts that includes zero, one, 128 and values above the store.
    initial begin : stimulus
        int count_plan [10];
        int pc;
        int k_eff;
        int idx;
        count_plan = '{1, 0, 3, 128, 255, 17, 2, 129, 64, 5};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // two points at opposite corners: t = 0 gives the last, t = 1.0 the first
        push_beat(bzp_pkg::KIND_LOAD, 0, 1023, 0, T_MAX_RAW);
        push_beat(bzp_pkg::KIND_LOAD, 1, 0, 1023, 0);
        push_beat(bzp_pkg::KIND_EVAL, 0, 0, 0, 0);
        push_beat(bzp_pkg::KIND_EVAL, 0, 0, 0, int'(bzp_pkg::T_ONE));
        push_beat(bzp_pkg::KIND_EVAL, 0, 0, 0, T_MAX_RAW);          // saturates to 1.0
        push_beat(bzp_pkg::KIND_EVAL, 0, 0, 0, int'(bzp_pkg::T_ONE) + 1);
        push_beat(bzp_pkg::KIND_EVAL, 0, 0, 0, 32768);
        push_beat(bzp_pkg::KIND_EVAL, 0, 0, 0, 1);
        push_beat(bzp_pkg::KIND_EVAL, 0, 0, 0, int'(bzp_pkg::T_ONE) - 1);
        // slot outside the curve; the evaluate ignores its unused fields
        push_beat(bzp_pkg::KIND_LOAD, 127, 1023, 1023, 65535);
        push_beat(bzp_pkg::KIND_EVAL, 127, 1023, 1023, 32768);
        push_beat(bzp_pkg::KIND_LOAD, 1, 512, 511, 0);
        push_beat(bzp_pkg::KIND_EVAL, 0, 0, 0, 21845);
        push_beat(bzp_pkg::KIND_LOAD, 0, 0, 0, 0);
        push_beat(bzp_pkg::KIND_EVAL, 0, 0, 0, 49152);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            pc = (ph < 10) ? count_plan[ph] : $urandom_range(4, 40);
            set_point_count(pc);
            k_eff = (pc == 0) ? 1
                  : ((pc > bzp_pkg::MAX_POINTS) ? bzp_pkg::MAX_POINTS : pc);
            // fill every slot the curve reads before any evaluate
            for (int i = 0; i < k_eff; i++) begin
                if (!slot_loaded[i])
                    push_beat(bzp_pkg::KIND_LOAD, i, pick_coord(), pick_coord(),
                              $urandom_range(0, T_MAX_RAW));
            end
            repeat (BEATS_PER_PHASE) begin
                if ($urandom_range(0, 99) < 55) begin
                    push_beat(bzp_pkg::KIND_EVAL, $urandom_range(0, bzp_pkg::MAX_POINTS - 1),
                              $urandom_range(0, 1023), $urandom_range(0, 1023), pick_t());
                end else begin
                    idx = ($urandom_range(0, 9) < 7)
                        ? $urandom_range(0, k_eff - 1)
                        : $urandom_range(0, bzp_pkg::MAX_POINTS - 1);
                    push_beat(bzp_pkg::KIND_LOAD, idx, pick_coord(), pick_coord(),
                              $urandom_range(0, T_MAX_RAW));
                end
            end
        end

        wait_drained();
        repeat (EVAL_DRAIN) @(posedge i_clk);
        if (expected_points.size() != 0) begin
            $error("%0d predicted results never arrived", expected_points.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
